// File: rtl/core/adad_pkg.sv
// Shared types, constants and the square root step for the Adadelta update block.
// No dependencies; adad_front, adad_back and the top level import it.
`default_nettype none

package adad_pkg;

   // Q8.24 constants
   localparam logic [24:0] Q_ONE   = 25'h100_0000;
   localparam logic [23:0] Q_HALF  = 24'h80_0000;
   localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

   // register indexes on the csr port
   localparam logic [1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [1:0] CSR_DECAY_FACTOR  = 2'd1;
   localparam logic [1:0] CSR_EPSILON       = 2'd2;

   // register reset values
   localparam logic [31:0] LEARNING_RATE_RST = 32'd16777216;
   localparam logic [24:0] DECAY_FACTOR_RST  = 25'd15099494;
   localparam logic [23:0] EPSILON_RST       = 24'd17;

   // square root: radicand below 2^57, so 29 result bits
   localparam int unsigned SQRT_STEPS   = 29;
   localparam logic [57:0] SQRT_TOP_BIT = 58'd1 << 56;
   // quotient of the lr*sn/sd division is 62 bits
   localparam int unsigned DIV_STEPS    = 62;

   typedef struct packed {
      logic [31:0] learning_rate;
      logic [24:0] decay_factor;
      logic [23:0] epsilon;
   } cfg_type;

   // classified input word as it sits in the queue
   typedef struct packed {
      logic [11:0] idx;
      logic        gneg;
      logic [31:0] gmag;
      logic [31:0] weight;
   } item_type;

   typedef struct packed {
      logic [57:0] rem;
      logic [57:0] root;
   } sqrt_type;

   // one digit of the bit-pair integer square root
   function automatic sqrt_type sqrt_step(input sqrt_type cur, input logic [57:0] bit_val);
      sqrt_type    nxt;
      logic [57:0] trial;
      trial = cur.root + bit_val;
      if (cur.rem >= trial) begin
         nxt.rem  = cur.rem - trial;
         nxt.root = (cur.root >> 1) + bit_val;
      end else begin
         nxt.rem  = cur.rem;
         nxt.root = cur.root >> 1;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/adad_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module adad_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/adad_queue.sv
// Small flop-based FIFO between the front and the back of the update block.
// No dependencies.
`default_nettype none

module adad_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [WIDTH-1:0]               push_data,
   input  wire logic                           pop,
   output logic      [WIDTH-1:0]               pop_data,
   output logic                                empty,
   output logic      [$clog2(DEPTH+1)-1:0]     count
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

`default_nettype wire

// File: rtl/core/adad_front.sv
// Front end: accepts input words, splits gradient sign and magnitude and maps
// the index onto a store slot. Depends on adad_pkg.
`default_nettype none

module adad_front #(
   parameter int unsigned NUM_ELEMENTS = 4096,
   parameter int unsigned QUEUE_DEPTH  = 4
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire logic                                           req_tvalid,
   output logic                                                req_tready,
   input  wire logic [79:0]                                    req_tdata,
   input  wire logic                                           clear_busy,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]               q_count,
   output logic                                                push,
   output adad_pkg::item_type                                  push_item,
   output logic [((NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1)-1:0] push_slot
);
   import adad_pkg::*;

   localparam int unsigned AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   // ceil(2^32 / N): exact floor(idx / N) for 12 bit idx
   localparam logic [32:0] RECIP =
      33'(((64'd1 << 32) + 64'(NUM_ELEMENTS) - 64'd1) / 64'(NUM_ELEMENTS));

   item_type     s1_item_ff, s1_item_in;
   logic [12:0]  s1_quo_ff,  s1_quo_in;
   logic         s1_vld_ff;
   logic         accept;
   logic [44:0]  quo_prod;
   logic [33:0]  sub_prod;
   logic [33:0]  rem_raw;
   logic [33:0]  rem_fix;

   // room for the word in stage 1 and the one being accepted
   assign req_tready = !clear_busy &&
                       ((CW + 1)'(q_count) + (CW + 1)'(s1_vld_ff) < (CW + 1)'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   // stage 0: sign/magnitude and the quotient estimate
   always_comb begin
      s1_item_in.idx    = req_tdata[11:0];
      s1_item_in.gneg   = req_tdata[43];
      s1_item_in.gmag   = req_tdata[43] ? (32'd0 - req_tdata[43:12]) : req_tdata[43:12];
      s1_item_in.weight = req_tdata[75:44];
      quo_prod          = 45'(req_tdata[11:0]) * 45'(RECIP);
      s1_quo_in         = quo_prod[44:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s1_item_in;
         s1_quo_ff  <= s1_quo_in;
      end
   end

   // stage 1: remainder with one correction, then into the queue
   always_comb begin
      sub_prod = 34'(s1_quo_ff) * 34'(NUM_ELEMENTS);
      rem_raw  = 34'(s1_item_ff.idx) - sub_prod;
      rem_fix  = (rem_raw >= 34'(NUM_ELEMENTS)) ? rem_raw - 34'(NUM_ELEMENTS) : rem_raw;
   end

   assign push      = s1_vld_ff;
   assign push_item = s1_item_ff;
   assign push_slot = rem_fix[AW-1:0];

endmodule

`default_nettype wire

// File: rtl/core/adad_back.sv
// Back end: per-element sequencer for the Adadelta arithmetic, the two average
// stores with their clearing pass, and the result register. Depends on adad_pkg, adad_ram.
`default_nettype none

module adad_back #(
   parameter int unsigned NUM_ELEMENTS = 4096
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire adad_pkg::cfg_type                              cfg,
   input  wire logic                                           q_empty,
   input  wire adad_pkg::item_type                             q_item,
   input  wire logic [((NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1)-1:0] q_slot,
   output logic                                                q_pop,
   output logic                                                clear_busy,
   output logic                                                rsp_tvalid,
   input  wire logic                                           rsp_tready,
   output logic [47:0]                                         rsp_tdata,
   output logic                                                rsp_tuser
);
   import adad_pkg::*;

   localparam int unsigned AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_SQR   = 4'd2;
   localparam logic [3:0] S_BLO   = 4'd3;
   localparam logic [3:0] S_BHI   = 4'd4;
   localparam logic [3:0] S_BFIN  = 4'd5;
   localparam logic [3:0] S_SQRT  = 4'd6;
   localparam logic [3:0] S_NUM   = 4'd7;
   localparam logic [3:0] S_DINIT = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_QH    = 4'd10;
   localparam logic [3:0] S_QL    = 4'd11;
   localparam logic [3:0] S_DM    = 4'd12;
   localparam logic [3:0] S_WO    = 4'd13;
   localparam logic [3:0] S_OUT   = 4'd14;

   // control
   logic [3:0]    state_ff, state_in;
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          rsp_vld_ff, rsp_vld_in;

   // payload
   logic [11:0]   idx_ff, idx_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic          gneg_ff, gneg_in;
   logic [31:0]   gmag_ff, gmag_in;
   logic [31:0]   w_ff, w_in;
   logic [31:0]   old_g_ff, old_g_in;
   logic [31:0]   old_u_ff, old_u_in;
   logic [63:0]   p_ff, p_in;
   logic [56:0]   p2_ff, p2_in;
   logic [40:0]   bx_ff, bx_in;
   logic [49:0]   lo_ff, lo_in;
   logic [41:0]   hi_ff, hi_in;
   logic          upd_ff, upd_in;
   logic          sat_ff, sat_in;
   sqrt_type      sq_n_ff, sq_n_in;
   sqrt_type      sq_d_ff, sq_d_in;
   logic [57:0]   sq_bit_ff, sq_bit_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [61:0]   num_ff, num_in;
   logic [28:0]   drem_ff, drem_in;
   logic [61:0]   quo_ff, quo_in;
   logic          ovf_ff, ovf_in;
   logic [31:0]   dmag_ff, dmag_in;
   logic [31:0]   wout_ff, wout_in;
   logic [11:0]   rsp_idx_ff, rsp_idx_in;
   logic [31:0]   rsp_w_ff, rsp_w_in;
   logic          rsp_sat_ff, rsp_sat_in;

   // datapath temporaries
   logic [24:0]   rho;
   logic [24:0]   rho_c;
   logic [31:0]   b_old;
   logic [43:0]   blend_sum;
   logic          blend_clip;
   logic [31:0]   blend_val;
   sqrt_type      sq_n_nxt;
   sqrt_type      sq_d_nxt;
   logic [28:0]   sd;
   logic [29:0]   trial;
   logic          trial_ge;
   logic [64:0]   dm_total;
   logic [64:0]   sq_round;
   logic [33:0]   wsum;
   logic          rsp_load;

   // RAM ports
   logic          rd_en;
   logic          g_we, u_we;
   logic [AW-1:0] wr_addr;
   logic [31:0]   g_wdata, u_wdata;
   logic [31:0]   g_rdata, u_rdata;

   adad_ram #(.WIDTH(32), .DEPTH(NUM_ELEMENTS)) u_grad_ram (
      .clock   (clock),
      .wr_en   (g_we),
      .wr_addr (wr_addr),
      .wr_data (g_wdata),
      .rd_en   (rd_en),
      .rd_addr (q_slot),
      .rd_data (g_rdata)
   );

   adad_ram #(.WIDTH(32), .DEPTH(NUM_ELEMENTS)) u_upd_ram (
      .clock   (clock),
      .wr_en   (u_we),
      .wr_addr (wr_addr),
      .wr_data (u_wdata),
      .rd_en   (rd_en),
      .rd_addr (q_slot),
      .rd_data (u_rdata)
   );

   // shared arithmetic
   always_comb begin
      rho        = (cfg.decay_factor > Q_ONE) ? Q_ONE : cfg.decay_factor;
      rho_c      = Q_ONE - rho;
      b_old      = upd_ff ? old_u_ff : old_g_ff;
      blend_sum  = 44'(hi_ff) + 44'(lo_ff >> 24);
      blend_clip = (blend_sum > 44'(U32_MAX));
      blend_val  = blend_clip ? U32_MAX : blend_sum[31:0];
      sq_n_nxt   = sqrt_step(sq_n_ff, sq_bit_ff);
      sq_d_nxt   = sqrt_step(sq_d_ff, sq_bit_ff);
      sd         = sq_d_ff.root[28:0];
      trial      = {drem_ff, num_ff[61]};
      trial_ge   = (trial >= 30'(sd));
      dm_total   = 65'(p_ff) + 65'(p2_ff >> 24);
      sq_round   = 65'(p_ff) + 65'(Q_HALF);
      wsum       = gneg_ff ? ({{2{w_ff[31]}}, w_ff} + 34'(dmag_ff))
                           : ({{2{w_ff[31]}}, w_ff} - 34'(dmag_ff));
   end

   assign q_pop    = (state_ff == S_IDLE) && !q_empty && !clr_busy_ff;
   assign rd_en    = q_pop;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_vld_ff || rsp_tready);

   // store writes: clearing pass or the two blend results
   always_comb begin
      g_we    = clr_busy_ff || ((state_ff == S_BFIN) && !upd_ff);
      u_we    = clr_busy_ff || ((state_ff == S_BFIN) && upd_ff);
      wr_addr = clr_busy_ff ? clr_addr_ff : slot_ff;
      g_wdata = clr_busy_ff ? 32'd0 : blend_val;
      u_wdata = clr_busy_ff ? 32'd0 : blend_val;
   end

   // clearing pass after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(NUM_ELEMENTS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      slot_in    = slot_ff;
      gneg_in    = gneg_ff;
      gmag_in    = gmag_ff;
      w_in       = w_ff;
      old_g_in   = old_g_ff;
      old_u_in   = old_u_ff;
      p_in       = p_ff;
      p2_in      = p2_ff;
      bx_in      = bx_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      upd_in     = upd_ff;
      sat_in     = sat_ff;
      sq_n_in    = sq_n_ff;
      sq_d_in    = sq_d_ff;
      sq_bit_in  = sq_bit_ff;
      cnt_in     = cnt_ff;
      num_in     = num_ff;
      drem_in    = drem_ff;
      quo_in     = quo_ff;
      ovf_in     = ovf_ff;
      dmag_in    = dmag_ff;
      wout_in    = wout_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_w_in   = rsp_w_ff;
      rsp_sat_in = rsp_sat_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;

      case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               idx_in   = q_item.idx;
               slot_in  = q_slot;
               gneg_in  = q_item.gneg;
               gmag_in  = q_item.gmag;
               w_in     = q_item.weight;
               state_in = S_RD;
            end
         end
         S_RD: begin
            old_g_in = g_rdata;
            old_u_in = u_rdata;
            p_in     = 64'(gmag_ff) * 64'(gmag_ff);
            sat_in   = 1'b0;
            upd_in   = 1'b0;
            state_in = S_SQR;
         end
         // round the square to Q17.24
         S_SQR: begin
            bx_in    = sq_round[64:24];
            state_in = S_BLO;
         end
         // blend, low fraction parts
         S_BLO: begin
            lo_in    = 50'(rho) * 50'(b_old[23:0]) + 50'(rho_c) * 50'(bx_ff[23:0]) +
                       50'(Q_HALF);
            state_in = S_BHI;
         end
         // blend, integer parts
         S_BHI: begin
            hi_in    = 42'(rho) * 42'(b_old[31:24]) + 42'(rho_c) * 42'(bx_ff[40:24]);
            state_in = S_BFIN;
         end
         S_BFIN: begin
            sat_in = sat_ff || blend_clip;
            if (upd_ff) begin
               state_in = S_OUT;
            end else begin
               sq_n_in.rem  = 58'(33'(old_u_ff) + 33'(cfg.epsilon)) << 24;
               sq_n_in.root = '0;
               sq_d_in.rem  = 58'(33'(blend_val) + 33'(cfg.epsilon)) << 24;
               sq_d_in.root = '0;
               sq_bit_in    = SQRT_TOP_BIT;
               cnt_in       = 6'(SQRT_STEPS - 1);
               state_in     = S_SQRT;
            end
         end
         // both square roots, one digit pair a cycle
         S_SQRT: begin
            sq_n_in   = sq_n_nxt;
            sq_d_in   = sq_d_nxt;
            sq_bit_in = sq_bit_ff >> 2;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (sq_d_nxt.root == '0) begin
                  dmag_in  = '0;
                  state_in = S_WO;
               end else begin
                  state_in = S_NUM;
               end
            end
         end
         S_NUM: begin
            p_in     = 64'(cfg.learning_rate) * 64'(sq_n_ff.root[28:0]);
            state_in = S_DINIT;
         end
         S_DINIT: begin
            num_in   = p_ff[61:0] + 62'(sd >> 1);
            drem_in  = '0;
            quo_in   = '0;
            cnt_in   = 6'(DIV_STEPS - 1);
            state_in = S_DIV;
         end
         // restoring division, one quotient bit a cycle
         S_DIV: begin
            drem_in = trial_ge ? 29'(trial - 30'(sd)) : trial[28:0];
            quo_in  = {quo_ff[60:0], trial_ge};
            num_in  = num_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_QH;
            end
         end
         // integer part of the ratio times |gradient|
         S_QH: begin
            p_in     = 64'(quo_ff[55:24]) * 64'(gmag_ff);
            ovf_in   = (quo_ff[61:56] != '0) && (gmag_ff != '0);
            state_in = S_QL;
         end
         // fraction part, rounded
         S_QL: begin
            p2_in    = 57'(quo_ff[23:0]) * 57'(gmag_ff) + 57'(Q_HALF);
            state_in = S_DM;
         end
         S_DM: begin
            if (ovf_ff || (dm_total > 65'(U32_MAX))) begin
               dmag_in = U32_MAX;
               sat_in  = 1'b1;
            end else begin
               dmag_in = dm_total[31:0];
            end
            state_in = S_WO;
         end
         // new weight with saturation, then square the update
         S_WO: begin
            if (!wsum[33] && (wsum[32:31] != 2'b00)) begin
               wout_in = 32'h7FFF_FFFF;
               sat_in  = 1'b1;
            end else if (wsum[33] && (wsum[32:31] != 2'b11)) begin
               wout_in = 32'h8000_0000;
               sat_in  = 1'b1;
            end else begin
               wout_in = wsum[31:0];
            end
            p_in     = 64'(dmag_ff) * 64'(dmag_ff);
            upd_in   = 1'b1;
            state_in = S_SQR;
         end
         S_OUT: begin
            if (rsp_load) begin
               rsp_idx_in = idx_ff;
               rsp_w_in   = wout_ff;
               rsp_sat_in = sat_ff;
               rsp_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      slot_ff    <= slot_in;
      gneg_ff    <= gneg_in;
      gmag_ff    <= gmag_in;
      w_ff       <= w_in;
      old_g_ff   <= old_g_in;
      old_u_ff   <= old_u_in;
      p_ff       <= p_in;
      p2_ff      <= p2_in;
      bx_ff      <= bx_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      upd_ff     <= upd_in;
      sat_ff     <= sat_in;
      sq_n_ff    <= sq_n_in;
      sq_d_ff    <= sq_d_in;
      sq_bit_ff  <= sq_bit_in;
      cnt_ff     <= cnt_in;
      num_ff     <= num_in;
      drem_ff    <= drem_in;
      quo_ff     <= quo_in;
      ovf_ff     <= ovf_in;
      dmag_ff    <= dmag_in;
      wout_ff    <= wout_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_w_ff   <= rsp_w_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign clear_busy = clr_busy_ff;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'd0, rsp_w_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_sat_ff;

endmodule

`default_nettype wire

// File: rtl/core/adadelta_weight_update_top.sv
// Adadelta weight update, top level: csr registers, front end, queue, back end.
// The back end handles one word at a time, through its 29-step square root and 62-step
// restoring divider; the queue holds further words meanwhile. When sqrt(grad_avg+eps)
// is zero the divider is skipped and the update magnitude is zero.
// Reset: synchronous, clears control and loads register defaults, then a clearing pass
// zeroes both average stores; req_tready stays low meanwhile.
`default_nettype none

module adadelta_weight_update_top #(
   parameter int unsigned NUM_ELEMENTS = 4096,
   parameter int unsigned QUEUE_DEPTH  = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // element_index[11:0], gradient[43:12], weight_in[75:44]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata,   // element_index_out[11:0], weight_out[43:12]
   output logic             rsp_tuser,   // saturated
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import adad_pkg::*;

   localparam int unsigned AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   cfg_type       cfg_ff, cfg_in;
   logic          push;
   item_type      push_item;
   logic [AW-1:0] push_slot;
   logic          pop;
   logic          q_empty;
   logic [CW-1:0] q_count;
   logic [AW+$bits(item_type)-1:0] q_data;
   logic          clear_busy;

   // configuration word write
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LEARNING_RATE: cfg_in.learning_rate = csr_data;
            CSR_DECAY_FACTOR:  cfg_in.decay_factor  = csr_data[24:0];
            CSR_EPSILON:       cfg_in.epsilon       = csr_data[23:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learning_rate <= LEARNING_RATE_RST;
         cfg_ff.decay_factor  <= DECAY_FACTOR_RST;
         cfg_ff.epsilon       <= EPSILON_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   adad_front #(.NUM_ELEMENTS(NUM_ELEMENTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .clear_busy (clear_busy),
      .q_count    (q_count),
      .push       (push),
      .push_item  (push_item),
      .push_slot  (push_slot)
   );

   adad_queue #(.WIDTH(AW + $bits(item_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_slot, push_item}),
      .pop       (pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .count     (q_count)
   );

   adad_back #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_item     (q_data[$bits(item_type)-1:0]),
      .q_slot     (q_data[AW+$bits(item_type)-1:$bits(item_type)]),
      .q_pop      (pop),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
